>>> design/b2d128_pkg.sv
package b2d128_pkg;

  // conversion size
  localparam int unsigned VALUE_BITS  = 128;
  localparam int unsigned DIGIT_COUNT = 39;

  // width of the two input halves and the joined word they form
  localparam int unsigned HALF_BITS = 64;
  localparam int unsigned WORD_BITS = 2 * HALF_BITS;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned BCNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned ECNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
    logic emit_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> design/b2d128_ctrl.sv
module b2d128_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  b2d128_pkg::dp_status_t status_i,
  output b2d128_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  logic [b2d128_pkg::BCNT_W-1:0]  bit_cnt_q;
  logic [b2d128_pkg::ECNT_W-1:0]  emit_cnt_q;

  logic bit_done;
  logic emit_done;

  assign bit_done  = (bit_cnt_q == b2d128_pkg::BCNT_W'(b2d128_pkg::VALUE_BITS - 1));
  assign emit_done = (emit_cnt_q == b2d128_pkg::ECNT_W'(b2d128_pkg::DIGIT_COUNT - 1));

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.shift     = (state_q == ST_SHIFT);
    cmd_o.emit      = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.emit_last = emit_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bit_cnt_q  <= '0;
      emit_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q   <= ST_SHIFT;
            bit_cnt_q <= '0;
          end
        end
        ST_SHIFT: begin
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_done) begin
            state_q    <= ST_EMIT;
            emit_cnt_q <= '0;
          end
        end
        ST_EMIT: begin
          if (status_i.out_free) begin
            if (emit_done) begin
              state_q <= ST_IDLE;
            end else begin
              emit_cnt_q <= emit_cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/b2d128_dp.sv
module b2d128_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [b2d128_pkg::HALF_BITS-1:0]     value_high_i,
  input  logic [b2d128_pkg::HALF_BITS-1:0]     value_low_i,
  input  b2d128_pkg::dp_cmd_t                  cmd_i,
  output b2d128_pkg::dp_status_t               status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [b2d128_pkg::DIGIT_W-1:0]       out_digit_o,
  output logic                                 out_last_o
);

  localparam int unsigned NDIG = b2d128_pkg::DIGIT_COUNT;
  localparam int unsigned DW   = b2d128_pkg::DIGIT_W;

  logic [b2d128_pkg::WORD_BITS-1:0]  word;
  logic [b2d128_pkg::VALUE_BITS-1:0] value_q;
  logic [DW-1:0]                     digit_q [NDIG];
  logic [DW-1:0]                     corr    [NDIG];
  logic [DW-1:0]                     dabbled [NDIG];
  logic [NDIG:0]                     carry;

  logic          out_valid_q;
  logic [DW-1:0] out_digit_q;
  logic          out_last_q;

  assign word = {value_high_i, value_low_i};

  // add-3 correction on every digit, then one bit shifted in from the value msb
  always_comb begin
    carry[0] = value_q[b2d128_pkg::VALUE_BITS-1];
    for (int k = 0; k < NDIG; k++) begin
      corr[k]    = (digit_q[k] >= DW'(5)) ? digit_q[k] + DW'(3) : digit_q[k];
      dabbled[k] = {corr[k][DW-2:0], carry[k]};
      carry[k+1] = corr[k][DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= word[b2d128_pkg::VALUE_BITS-1:0];
      for (int k = 0; k < NDIG; k++) begin
        digit_q[k] <= '0;
      end
    end else if (cmd_i.shift) begin
      value_q <= {value_q[b2d128_pkg::VALUE_BITS-2:0], 1'b0};
      for (int k = 0; k < NDIG; k++) begin
        digit_q[k] <= dabbled[k];
      end
    end else if (cmd_i.emit) begin
      // move the next lower digit up to the top
      digit_q[0] <= '0;
      for (int k = 1; k < NDIG; k++) begin
        digit_q[k] <= digit_q[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_digit_q <= digit_q[NDIG-1];
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_digit_o       = out_digit_q;
  assign out_last_o        = out_last_q;

endmodule

>>> design/binary_to_decimal_128_core.sv
// channel   | dir | tdata fields (low bit up)              | tuser | tlast
// s_axis    | in  | value_high [63:0], value_low [127:64]   | -     | -
// m_axis    | out | digit [3:0], zero fill [7:4]            | -     | last_digit
//
// one beat in is taken in the idle state, then VALUE_BITS shift steps run in
// the double dabble loop and DIGIT_COUNT digit beats go out, most significant
// digit first; emission waits while a digit sits in the output register with
// m_axis_tready low
// s_axis_tready is high only while no value is being converted; the final
// digit may still sit in the output register when the next value is taken
// reset is asynchronous, active low, and clears the controller and the
// output valid flag; the digit store is cleared on every accepted value
module binary_to_decimal_128_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // value_high [63:0], value_low [127:64]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o,  // digit [3:0], zero [7:4]
  output logic         m_axis_tlast_o   // last_digit
);

  b2d128_pkg::dp_cmd_t    cmd;
  b2d128_pkg::dp_status_t status;

  logic [b2d128_pkg::DIGIT_W-1:0] digit;

  // sequencer: idle, shift loop, digit emission
  b2d128_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // value shifter, bcd digit store and output register
  b2d128_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_high_i (s_axis_tdata_i[63:0]),
    .value_low_i  (s_axis_tdata_i[127:64]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_digit_o  (digit),
    .out_last_o   (m_axis_tlast_o)
  );

  // digit in the low nibble, upper bits zero filled
  assign m_axis_tdata_o = {{(b2d128_pkg::OUT_DATA_W - b2d128_pkg::DIGIT_W){1'b0}}, digit};

endmodule

>>> design/b2d128_checker.sv
module b2d128_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [127:0] s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [7:0]   m_axis_tdata_o,
  input logic         m_axis_tlast_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  // every digit is decimal and the fill bits stay zero
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[3:0] <= 4'd9) && (m_axis_tdata_o[7:4] == 4'd0))
    else $error("digit out of range");

  // the converter goes busy once a value is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still ready after accept");

  // while idle only the final digit of a run can be pending
  a_idle_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("ready for input with digits outstanding");

endmodule

bind binary_to_decimal_128_core b2d128_checker u_b2d128_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
